// ===== rtl/tpd_pkg.sv =====
package tpd_pkg;

    localparam int CountWidth  = 16;
    localparam int TotalWidth  = 20;
    localparam int MiddleWidth = 19;
    localparam int CfgIndexWidth = 1;

    localparam logic [3:0] CAL_SAMPLES     = 4'd10;
    localparam logic [1:0] SCAN_SAMPLES    = 2'd3;
    localparam logic [1:0] HOLDOFF_RELOAD  = 2'd3;

    // floor(x / 6) == (x * RECIP_SIX) >> RecipShift for x below 2**19
    localparam int RecipShift = 20;
    localparam int RecipWidth = 18;
    localparam logic [RecipWidth-1:0] RECIP_SIX = 18'd174763;

    localparam logic [CountWidth-1:0] GATE_RESET = 16'd100;
    localparam logic [CountWidth-1:0] TOP_RESET  = 16'hFFFF;

    typedef enum logic {
        OP_CAL  = 1'b0,
        OP_SCAN = 1'b1
    } opcode_t;

    typedef enum logic {
        KIND_CAL  = 1'b0,
        KIND_SCAN = 1'b1
    } kind_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_GATE_THRESHOLD = 1'b0,
        REG_COUNTER_TOP    = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic                   valid;
        kind_t                  kind;
        logic [MiddleWidth-1:0] value;
    } token_t;

    typedef struct packed {
        kind_t                 kind;
        logic [CountWidth-1:0] baseline;
        logic                  fault;
        logic                  pressed;
        logic [CountWidth-1:0] peak;
    } result_t;

endpackage

// ===== rtl/tpd_accum.sv =====
module tpd_accum
    import tpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  opcode,
    input  logic [CountWidth-1:0] charge_count,
    output token_t                token
);

    logic [3:0]            cal_count_reg, cal_count_next;
    logic [TotalWidth-1:0] cal_total_reg, cal_total_next;
    logic [CountWidth-1:0] lo0_reg, lo0_next, lo1_reg, lo1_next;
    logic [CountWidth-1:0] hi0_reg, hi0_next, hi1_reg, hi1_next;
    logic [1:0]            scan_count_reg, scan_count_next;
    logic [CountWidth-1:0] peak_reg, peak_next;

    logic [TotalWidth-1:0] total_sum;
    logic [CountWidth-1:0] lo0_new, lo1_new, hi0_new, hi1_new;
    logic [3:0]            cal_inc;
    logic [1:0]            scan_inc;
    logic [CountWidth-1:0] peak_new;
    logic [TotalWidth-1:0] middle;

    always_comb
    begin
        total_sum = cal_total_reg + TotalWidth'(charge_count);
        lo0_new = lo0_reg;
        lo1_new = lo1_reg;
        hi0_new = hi0_reg;
        hi1_new = hi1_reg;
        if (charge_count < lo0_reg)
        begin
            lo1_new = lo0_reg;
            lo0_new = charge_count;
        end
        else if (charge_count < lo1_reg)
        begin
            lo1_new = charge_count;
        end
        if (charge_count > hi0_reg)
        begin
            hi1_new = hi0_reg;
            hi0_new = charge_count;
        end
        else if (charge_count > hi1_reg)
        begin
            hi1_new = charge_count;
        end
        cal_inc  = cal_count_reg + 4'd1;
        scan_inc = scan_count_reg + 2'd1;
        peak_new = (charge_count > peak_reg) ? charge_count : peak_reg;
        middle = total_sum - TotalWidth'(lo0_new) - TotalWidth'(lo1_new)
                 - TotalWidth'(hi0_new) - TotalWidth'(hi1_new);
    end

    always_comb
    begin
        cal_count_next  = cal_count_reg;
        cal_total_next  = cal_total_reg;
        lo0_next        = lo0_reg;
        lo1_next        = lo1_reg;
        hi0_next        = hi0_reg;
        hi1_next        = hi1_reg;
        scan_count_next = scan_count_reg;
        peak_next       = peak_reg;
        token.valid     = 1'b0;
        token.kind      = KIND_CAL;
        token.value     = '0;
        case (opcode_t'(opcode))
            OP_CAL:
            begin
                if (cal_inc == CAL_SAMPLES)
                begin
                    token.valid    = 1'b1;
                    token.kind     = KIND_CAL;
                    token.value    = middle[MiddleWidth-1:0];
                    cal_count_next = '0;
                    cal_total_next = '0;
                    lo0_next       = '1;
                    lo1_next       = '1;
                    hi0_next       = '0;
                    hi1_next       = '0;
                end
                else
                begin
                    cal_count_next = cal_inc;
                    cal_total_next = total_sum;
                    lo0_next       = lo0_new;
                    lo1_next       = lo1_new;
                    hi0_next       = hi0_new;
                    hi1_next       = hi1_new;
                end
            end
            OP_SCAN:
            begin
                if (scan_inc == SCAN_SAMPLES)
                begin
                    token.valid     = 1'b1;
                    token.kind      = KIND_SCAN;
                    token.value     = MiddleWidth'(peak_new);
                    scan_count_next = '0;
                    peak_next       = '0;
                end
                else
                begin
                    scan_count_next = scan_inc;
                    peak_next       = peak_new;
                end
            end
            default:
            begin
                token.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_count_reg  <= '0;
            cal_total_reg  <= '0;
            lo0_reg        <= '1;
            lo1_reg        <= '1;
            hi0_reg        <= '0;
            hi1_reg        <= '0;
            scan_count_reg <= '0;
            peak_reg       <= '0;
        end
        else if (en)
        begin
            cal_count_reg  <= cal_count_next;
            cal_total_reg  <= cal_total_next;
            lo0_reg        <= lo0_next;
            lo1_reg        <= lo1_next;
            hi0_reg        <= hi0_next;
            hi1_reg        <= hi1_next;
            scan_count_reg <= scan_count_next;
            peak_reg       <= peak_next;
        end
    end

endmodule

// ===== rtl/tpd_judge.sv =====
module tpd_judge
    import tpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  token_t                token,
    input  logic [CountWidth-1:0] gate_threshold,
    input  logic [CountWidth-1:0] counter_top,
    output result_t               result
);

    localparam int ProdWidth = MiddleWidth + RecipWidth;

    logic [CountWidth-1:0] baseline_reg, baseline_next;
    logic [1:0]            holdoff_reg, holdoff_next;

    logic [ProdWidth-1:0]  product;
    logic [CountWidth-1:0] quotient;
    logic [CountWidth:0]   threshold;
    logic                  over;
    logic [1:0]            holdoff_loaded;

    always_comb
    begin
        product  = ProdWidth'(token.value) * ProdWidth'(RECIP_SIX);
        quotient = product[RecipShift +: CountWidth];
        threshold = {1'b0, baseline_reg} + {1'b0, gate_threshold};
        over = {1'b0, token.value[CountWidth-1:0]} > threshold;
        holdoff_loaded = over ? HOLDOFF_RELOAD : holdoff_reg;
    end

    always_comb
    begin
        baseline_next   = baseline_reg;
        holdoff_next    = holdoff_reg;
        result.kind     = token.kind;
        result.baseline = baseline_reg;
        result.fault    = 1'b0;
        result.pressed  = 1'b0;
        result.peak     = '0;
        case (token.kind)
            KIND_CAL:
            begin
                baseline_next   = quotient;
                result.baseline = quotient;
                result.fault    = quotient > (counter_top >> 1);
            end
            KIND_SCAN:
            begin
                result.pressed = over && (holdoff_reg == 2'd0);
                result.peak    = token.value[CountWidth-1:0];
                holdoff_next   = (holdoff_loaded != 2'd0) ? holdoff_loaded - 2'd1 : 2'd0;
            end
            default:
            begin
                result.fault = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= '0;
            holdoff_reg  <= '0;
        end
        else if (en && token.valid)
        begin
            baseline_reg <= baseline_next;
            holdoff_reg  <= holdoff_next;
        end
    end

endmodule

// ===== rtl/touch_pad_press_detector.sv =====
// Charge-time press detector for one capacitive pad. Calibration samples
// (opcode 0) are gathered in groups of ten; the tenth gives a result with the
// new baseline (mean of the middle six) and a fault flag when the baseline is
// above half of counter_top. Scan samples (opcode 1) are gathered in groups
// of three; the third gives a verdict with the group peak and a press flag,
// which is set only on a new touch after the hold-off has run out. Other
// samples give no result. One sample is taken every clock cycle while in_ready
// is high. An accepted sample passes an input register, the running min/max/sum
// stage and the reciprocal-multiply/compare stage before its result reaches the
// output register. Configuration writes take effect at once and are meant for
// idle periods only.
module touch_pad_press_detector
    import tpd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CountWidth-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     opcode,
    input  logic [CountWidth-1:0]    charge_count,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     result_kind,
    output logic [CountWidth-1:0]    baseline,
    output logic                     calibration_fault,
    output logic                     pressed,
    output logic [CountWidth-1:0]    scan_peak
);

    logic [CountWidth-1:0] gate_reg, top_reg;

    logic                  s_valid_reg;
    logic                  s_opcode_reg;
    logic [CountWidth-1:0] s_count_reg;

    token_t  token_next, token_reg;
    result_t result_next, result_reg;
    logic    out_valid_reg;

    logic out_free, p_free, p_go, s_go, s_free;

    assign out_free = !out_valid_reg || out_ready;
    assign p_free   = !token_reg.valid || out_free;
    assign p_go     = token_reg.valid && out_free;
    assign s_go     = s_valid_reg && p_free;
    assign s_free   = !s_valid_reg || p_free;
    assign in_ready = s_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg <= GATE_RESET;
            top_reg  <= TOP_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_GATE_THRESHOLD: gate_reg <= cfg_data;
                REG_COUNTER_TOP:    top_reg  <= cfg_data;
                default:            gate_reg <= gate_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (s_free)
        begin
            s_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_free && in_valid)
        begin
            s_opcode_reg <= opcode;
            s_count_reg  <= charge_count;
        end
    end

    tpd_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (s_go),
        .opcode       (s_opcode_reg),
        .charge_count (s_count_reg),
        .token        (token_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
        end
        else
        begin
            if (p_free)
            begin
                token_reg.valid <= s_valid_reg && token_next.valid;
            end
            if (s_go && token_next.valid)
            begin
                token_reg.kind  <= token_next.kind;
                token_reg.value <= token_next.value;
            end
        end
    end

    tpd_judge u_judge (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (p_go),
        .token          (token_reg),
        .gate_threshold (gate_reg),
        .counter_top    (top_reg),
        .result         (result_next)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= token_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_go)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign result_kind       = result_reg.kind;
    assign baseline          = result_reg.baseline;
    assign calibration_fault = result_reg.fault;
    assign pressed           = result_reg.pressed;
    assign scan_peak         = result_reg.peak;

endmodule

// ===== tb/tb_touch_pad_press_detector.sv =====
`timescale 1ns / 100ps

module tb_touch_pad_press_detector;
    import tpd_pkg::*;

    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 10;
    localparam int KEPT_SAMPLES  = 6;
    localparam int COUNT_MAX     = 65535;
    localparam int PHASE_ITEMS   = 250;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CountWidth-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     opcode;
    logic [CountWidth-1:0]    charge_count;
    logic                     out_valid;
    logic                     out_ready;
    logic                     result_kind;
    logic [CountWidth-1:0]    baseline;
    logic                     calibration_fault;
    logic                     pressed;
    logic [CountWidth-1:0]    scan_peak;

    // predictor state
    logic [CountWidth-1:0] gate_margin;
    logic [CountWidth-1:0] timer_top;
    logic [3:0]            cal_seen;
    logic [TotalWidth-1:0] cal_sum;
    logic [CountWidth-1:0] low_min;
    logic [CountWidth-1:0] low_next;
    logic [CountWidth-1:0] high_max;
    logic [CountWidth-1:0] high_next;
    logic [CountWidth-1:0] base_level;
    logic [1:0]            scan_seen;
    logic [CountWidth-1:0] scan_max;
    logic [1:0]            holdoff_left;

    result_t expected_verdicts[$];
    result_t observed;
    result_t wanted;

    int sender_idle_pct;
    int receiver_stall_pct;
    int mismatches;
    int cal_center;
    int cal_spread;

    touch_pad_press_detector dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .charge_count      (charge_count),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_kind       (result_kind),
        .baseline          (baseline),
        .calibration_fault (calibration_fault),
        .pressed           (pressed),
        .scan_peak         (scan_peak)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function void restart_cal_group();
        cal_seen  = '0;
        cal_sum   = '0;
        low_min   = '1;
        low_next  = '1;
        high_max  = '0;
        high_next = '0;
    endfunction

    function void predict_sample(opcode_t op, logic [CountWidth-1:0] x);
        logic [31:0]           middle;
        logic [CountWidth-1:0] peak;
        logic [CountWidth:0]   trip_level;
        result_t               verdict;
        if (op == OP_CAL)
        begin
            cal_sum = cal_sum + x;
            if (x < low_min)
            begin
                low_next = low_min;
                low_min  = x;
            end
            else if (x < low_next)
                low_next = x;
            if (x > high_max)
            begin
                high_next = high_max;
                high_max  = x;
            end
            else if (x > high_next)
                high_next = x;
            cal_seen = cal_seen + 1'b1;
            if (cal_seen >= CAL_SAMPLES)
            begin
                middle = {12'd0, cal_sum} - low_min - low_next - high_max - high_next;
                base_level = CountWidth'(middle / KEPT_SAMPLES);
                verdict.kind     = KIND_CAL;
                verdict.baseline = base_level;
                verdict.fault    = (base_level > (timer_top >> 1));
                verdict.pressed  = 1'b0;
                verdict.peak     = '0;
                expected_verdicts.push_back(verdict);
                restart_cal_group();
            end
        end
        else
        begin
            peak = (x > scan_max) ? x : scan_max;
            scan_seen = scan_seen + 1'b1;
            if (scan_seen < SCAN_SAMPLES)
                scan_max = peak;
            else
            begin
                scan_seen = '0;
                scan_max  = '0;
                verdict.pressed = 1'b0;
                trip_level = {1'b0, base_level} + {1'b0, gate_margin};
                if ({1'b0, peak} > trip_level)
                begin
                    if (holdoff_left == 2'd0)
                        verdict.pressed = 1'b1;
                    holdoff_left = HOLDOFF_RELOAD;
                end
                if (holdoff_left != 2'd0)
                    holdoff_left = holdoff_left - 1'b1;
                verdict.kind     = KIND_SCAN;
                verdict.baseline = base_level;
                verdict.fault    = 1'b0;
                verdict.peak     = peak;
                expected_verdicts.push_back(verdict);
            end
        end
    endfunction

    function automatic string show(result_t r);
        return $sformatf("kind=%0d baseline=%0d fault=%0d pressed=%0d peak=%0d",
                         r.kind, r.baseline, r.fault, r.pressed, r.peak);
    endfunction

    function automatic logic [CountWidth-1:0] near(int center, int spread);
        int v;
        v = center - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0)
            v = 0;
        else if (v > COUNT_MAX)
            v = COUNT_MAX;
        return v[CountWidth-1:0];
    endfunction

    function automatic logic [CountWidth-1:0] cal_value();
        if ($urandom_range(0, 9) == 0)
            return CountWidth'($urandom_range(0, COUNT_MAX));
        return near(cal_center, cal_spread);
    endfunction

    function automatic logic [CountWidth-1:0] scan_value();
        if ($urandom_range(0, 3) == 0)
            return CountWidth'($urandom_range(0, COUNT_MAX));
        return near(int'(base_level) + int'(gate_margin), 300);
    endfunction

    task automatic send_sample(opcode_t op, logic [CountWidth-1:0] x);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        charge_count <= x;
        do
            @(posedge clk);
        while (!in_ready);
        predict_sample(op, x);
    endtask

    // drain results, then let samples that give no result leave the pipeline
    task automatic wait_for_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(reg_index_t idx, logic [CountWidth-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_GATE_THRESHOLD)
            gate_margin = value;
        else
            timer_top = value;
    endtask

    task automatic test_scan_before_calibration();
        send_sample(OP_SCAN, 16'd0);
        send_sample(OP_SCAN, 16'hFFFF);
        send_sample(OP_SCAN, 16'd50);
    endtask

    task automatic test_calibration_extremes();
        send_sample(OP_CAL, 16'd40000);
        send_sample(OP_CAL, 16'd0);
        send_sample(OP_CAL, 16'd40000);
        send_sample(OP_CAL, 16'hFFFF);
        send_sample(OP_CAL, 16'd40000);
        send_sample(OP_CAL, 16'd0);
        send_sample(OP_CAL, 16'd40000);
        send_sample(OP_CAL, 16'hFFFF);
        send_sample(OP_CAL, 16'd40000);
        send_sample(OP_CAL, 16'd40000);
    endtask

    task automatic test_interleaved_groups();
        send_sample(OP_CAL, 16'd500);
        send_sample(OP_CAL, 16'd700);
        send_sample(OP_SCAN, 16'hFFFF);
        send_sample(OP_CAL, 16'd510);
        send_sample(OP_CAL, 16'd90);
        send_sample(OP_CAL, 16'd520);
        send_sample(OP_SCAN, 16'd1);
        send_sample(OP_CAL, 16'd530);
        send_sample(OP_CAL, 16'd900);
        send_sample(OP_CAL, 16'd540);
        send_sample(OP_SCAN, 16'd2);
        send_sample(OP_CAL, 16'd550);
        send_sample(OP_CAL, 16'd60);
        // peak exactly at the threshold is not a touch
        send_sample(OP_SCAN, base_level + gate_margin);
        send_sample(OP_SCAN, 16'd0);
        send_sample(OP_SCAN, base_level + gate_margin - 1'b1);
    endtask

    task automatic run_random_phase(int idle_pct, int stall_pct);
        int sent;
        int pick;
        int k;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        cal_center = $urandom_range(0, 60000);
        cal_spread = $urandom_range(0, 3000);
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    cal_center = $urandom_range(0, 60000);
                    cal_spread = $urandom_range(0, 3000);
                end
                for (k = 0; k < CAL_SAMPLES; k++)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        send_sample(OP_SCAN, scan_value());
                        sent++;
                    end
                    send_sample(OP_CAL, cal_value());
                    sent++;
                end
            end
            else if (pick < 85)
            begin
                for (k = 0; k < SCAN_SAMPLES; k++)
                begin
                    send_sample(OP_SCAN, scan_value());
                    sent++;
                end
            end
            else
            begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                begin
                    send_sample(($urandom_range(0, 1) == 0) ? OP_CAL : OP_SCAN,
                                CountWidth'($urandom_range(0, COUNT_MAX)));
                    sent++;
                end
            end
        end
        wait_for_idle();
    endtask

    task automatic test_random_traffic();
        wait_for_idle();
        write_register(REG_GATE_THRESHOLD, 16'd0);
        write_register(REG_COUNTER_TOP, 16'd1);
        run_random_phase(0, 0);
        write_register(REG_GATE_THRESHOLD, 16'hFFFF);
        write_register(REG_COUNTER_TOP, 16'hFFFF);
        run_random_phase(62, 0);
        write_register(REG_GATE_THRESHOLD, CountWidth'($urandom_range(0, 2000)));
        write_register(REG_COUNTER_TOP, 16'd0);
        run_random_phase(0, 62);
        write_register(REG_GATE_THRESHOLD, CountWidth'($urandom_range(0, 2000)));
        write_register(REG_COUNTER_TOP, CountWidth'($urandom_range(1, COUNT_MAX)));
        run_random_phase(20, 20);
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            observed.kind     = kind_t'(result_kind);
            observed.baseline = baseline;
            observed.fault    = calibration_fault;
            observed.pressed  = pressed;
            observed.peak     = scan_peak;
            if (expected_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected transaction %s", $time, show(observed));
            end
            else
            begin
                wanted = expected_verdicts.pop_front();
                if (observed.kind !== wanted.kind || observed.baseline !== wanted.baseline
                    || observed.fault !== wanted.fault || observed.pressed !== wanted.pressed
                    || observed.peak !== wanted.peak)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected %s\n    actual   %s",
                                 $time, show(wanted), show(observed));
                end
            end
        end
    end

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_GATE_THRESHOLD;
        cfg_data           = '0;
        in_valid           = 1'b0;
        opcode             = OP_CAL;
        charge_count       = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatches         = 0;
        cal_center         = 0;
        cal_spread         = 0;
        gate_margin        = GATE_RESET;
        timer_top          = TOP_RESET;
        base_level         = '0;
        scan_seen          = '0;
        scan_max           = '0;
        holdoff_left       = '0;
        restart_cal_group();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_scan_before_calibration();
        test_calibration_extremes();
        test_interleaved_groups();
        test_random_traffic();

        mismatches += expected_verdicts.size();
        if (mismatches == 0)
            $display("tb_touch_pad_press_detector OK");
        else
            $display("tb_touch_pad_press_detector NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_touch_pad_press_detector NOT OK");
        $finish;
    end

endmodule
